// ===== rtl/lse_pkg.sv =====
// Package with shared constants and codes for the LSB steganography block.
`timescale 1ns / 1ps
`default_nettype none
package lse_pkg;

	// Default sizing of the block
	localparam int HEADER_BITS_DEF   = 32;
	localparam int MESSAGE_DEPTH_DEF = 256;

	// Fixed field widths
	localparam int BYTE_W     = 8;
	localparam int INDEX_W    = 8;
	localparam int POS_W      = 32;
	localparam int DECL_W     = 29;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Input command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_COVER = 1'b1;

	// Mode register codes
	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	// Result kind codes
	localparam logic KIND_COVER   = 1'b0;
	localparam logic KIND_MESSAGE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COVER_SIZE    = 2'd2;

endpackage : lse_pkg
`default_nettype wire

// ===== rtl/lse_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface lse_in_if;
	import lse_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [BYTE_W-1:0]    data_byte;
	logic [INDEX_W-1:0]   message_index;
	logic                 first_of_image;

	modport source (output valid, command, data_byte, message_index, first_of_image,
		input ready);
	modport sink (input valid, command, data_byte, message_index, first_of_image,
		output ready);
endinterface : lse_in_if

interface lse_out_if;
	import lse_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 result_kind;
	logic [BYTE_W-1:0]    value;
	logic                 too_large;
	logic [DECL_W-1:0]    declared_length_bytes;
	logic                 last_message_byte;

	modport source (output valid, result_kind, value, too_large, declared_length_bytes,
		last_message_byte, input ready);
	modport sink (input valid, result_kind, value, too_large, declared_length_bytes,
		last_message_byte, output ready);
endinterface : lse_out_if
`default_nettype wire

// ===== rtl/lse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule : lse_ram
`default_nettype wire

// ===== rtl/lsb_stego_embed_extract.sv =====
// LSB steganography embedder and extractor with a message length header.
//
// Usage: the item channel carries message loads (command 0) and cover bytes
// (command 1). Loads write the message store and give no result. In embed
// mode every cover byte gives one result: the byte with its LSB replaced by
// the length header (message_bytes * 8, MSB first, HEADER_BITS bits), then
// by the message bits, then unchanged; if the message does not fit in
// cover_size every byte passes unchanged with too_large set. In extract mode
// the header is collected from the LSBs and one result is given for every
// eight message bits; header and tail bytes give nothing.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data; the user
// must write it only while the block is idle, as the block does not enforce
// this. Throughput: one transaction per cycle while the receiver is ready.
// An item passes stage one and the store read, then the result register.
// Reset clears the position counter, header, bit accumulator, configuration and
// valid flags; the message store is not cleared and must be loaded before use.
// When the receiver stalls, the result register holds and the pipeline
// backs up; the input keeps accepting while a free stage remains.
`timescale 1ns / 1ps
`default_nettype none
module lsb_stego_embed_extract
	import lse_pkg::*;
#(
	parameter int HEADER_BITS   = HEADER_BITS_DEF,
	parameter int MESSAGE_DEPTH = MESSAGE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lse_in_if.sink                     item,
	lse_out_if.source                  result,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);
	localparam int AW    = $clog2(MESSAGE_DEPTH);
	localparam int LEN_W = BYTE_W + 3;

	// Stage one payload: what the result stage needs beyond the store byte
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic              big;
		logic              sel_hdr;
		logic              sel_msg;
		logic              hdr_bit;
		logic [2:0]        bit_idx;
		logic [BYTE_W-1:0] msg_byte;
		logic [DECL_W-1:0] decl;
		logic              last;
	} stage_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] value;
		logic              too_large;
		logic [DECL_W-1:0] decl;
		logic              last;
	} res_t;

	// Configuration registers
	logic              mode_q;
	logic [BYTE_W-1:0] msg_bytes_q;
	logic [POS_W-1:0]  cover_size_q;

	// Stream state
	logic [POS_W-1:0]  cover_pos_q;
	logic [POS_W-1:0]  hdr_len_q;
	logic [BYTE_W-1:0] acc_q;
	logic [2:0]        bit_cnt_q;

	// Pipeline
	logic              valid_s1;
	stage_t            pay_s1;
	logic              out_valid_q;
	res_t              out_q;

	logic              advance;
	logic              accept;
	logic              cover_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_EMBED;
			msg_bytes_q  <= '0;
			cover_size_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:          mode_q       <= cfg_wr_data[0];
				REG_MESSAGE_BYTES: msg_bytes_q  <= cfg_wr_data[BYTE_W-1:0];
				REG_COVER_SIZE:    cover_size_q <= cfg_wr_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the result register frees when empty or taken; stage one
	// frees when empty or moving on.
	assign advance    = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;
	assign cover_acc  = accept && (item.command == CMD_COVER);

	// Current state with a new-image mark applied
	logic [POS_W-1:0]  pos_cur;
	logic [POS_W-1:0]  hdr_cur;
	logic [BYTE_W-1:0] acc_cur;
	logic [2:0]        bit_cur;
	logic [POS_W-1:0]  pos_next;
	logic [POS_W-1:0]  pos_off;
	logic              in_hdr;
	logic [LEN_W-1:0]  len;
	logic [POS_W-1:0]  len32;
	logic              big;
	logic              emb_msg;
	logic              ext_msg;
	logic [4:0]        hdr_k;
	logic              lsb;
	logic [BYTE_W-1:0] acc_new;
	logic [POS_W-1:0]  total;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [AW+INDEX_W-1:0] idx_ext;

	always_comb begin
		pos_cur  = item.first_of_image ? '0 : cover_pos_q;
		hdr_cur  = item.first_of_image ? '0 : hdr_len_q;
		acc_cur  = item.first_of_image ? '0 : acc_q;
		bit_cur  = item.first_of_image ? '0 : bit_cnt_q;
		// saturate the position at all ones
		pos_next = (&pos_cur) ? pos_cur : pos_cur + POS_W'(1);
		pos_off  = pos_cur - POS_W'(HEADER_BITS);
		in_hdr   = pos_cur < POS_W'(HEADER_BITS);
		lsb      = item.data_byte[0];

		len   = {msg_bytes_q, 3'b000};
		len32 = POS_W'(len);
		big   = (33'(len) + 33'(HEADER_BITS)) > {1'b0, cover_size_q};
		hdr_k = 5'(HEADER_BITS - 1) - pos_cur[4:0];

		emb_msg = !in_hdr && (pos_off < len32);
		ext_msg = !in_hdr && (pos_off < hdr_cur);
		acc_new = {acc_cur[BYTE_W-2:0], lsb};
		total   = hdr_cur >> 3;

		rd_addr = pos_off[AW+2:3];
		idx_ext = {{AW{1'b0}}, item.message_index};
		wr_addr = idx_ext[AW-1:0];
	end

	// Stream state: advances on every accepted cover byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_pos_q <= '0;
			hdr_len_q   <= '0;
			acc_q       <= '0;
			bit_cnt_q   <= '0;
		end else if (cover_acc) begin
			cover_pos_q <= pos_next;
			hdr_len_q   <= hdr_cur;
			acc_q       <= acc_cur;
			bit_cnt_q   <= bit_cur;
			if (mode_q == MODE_EXTRACT) begin
				if (in_hdr) begin
					hdr_len_q <= {hdr_cur[POS_W-2:0], lsb};
				end else if (ext_msg) begin
					acc_q     <= acc_new;
					bit_cnt_q <= bit_cur + 3'd1;
				end
			end
		end
	end

	// Message store: loads write, cover bytes fetch the byte they may need
	logic [BYTE_W-1:0] store_byte;

	lse_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MESSAGE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && (item.command == CMD_LOAD)),
		.wr_addr (wr_addr),
		.wr_data (item.data_byte),
		.rd_en   (cover_acc),
		.rd_addr (rd_addr),
		.rd_data (store_byte)
	);

	// Stage one: an item goes on only if it will give a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= cover_acc &&
				((mode_q == MODE_EMBED) || (ext_msg && (bit_cur == 3'd7)));
		end
	end

	always_ff @(posedge clk) begin
		if (cover_acc) begin
			pay_s1.kind     <= (mode_q == MODE_EMBED) ? KIND_COVER : KIND_MESSAGE;
			pay_s1.data     <= item.data_byte;
			pay_s1.big      <= big;
			pay_s1.sel_hdr  <= in_hdr;
			pay_s1.sel_msg  <= emb_msg;
			pay_s1.hdr_bit  <= len32[hdr_k];
			pay_s1.bit_idx  <= pos_off[2:0];
			pay_s1.msg_byte <= acc_new;
			pay_s1.decl     <= total[DECL_W-1:0];
			pay_s1.last     <= ((pos_off >> 3) + POS_W'(1)) == total;
		end
	end

	// Result stage
	res_t res_d;
	logic emb_bit;

	always_comb begin
		if (pay_s1.sel_hdr) begin
			emb_bit = pay_s1.hdr_bit;
		end else if (pay_s1.sel_msg) begin
			emb_bit = store_byte[3'd7 - pay_s1.bit_idx];
		end else begin
			emb_bit = pay_s1.data[0];
		end

		res_d.kind = pay_s1.kind;
		if (pay_s1.kind == KIND_COVER) begin
			res_d.value     = pay_s1.big ? pay_s1.data : {pay_s1.data[BYTE_W-1:1], emb_bit};
			res_d.too_large = pay_s1.big;
			res_d.decl      = '0;
			res_d.last      = 1'b0;
		end else begin
			res_d.value     = pay_s1.msg_byte;
			res_d.too_large = 1'b0;
			res_d.decl      = pay_s1.decl;
			res_d.last      = pay_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res_d;
		end
	end

	assign result.valid                 = out_valid_q;
	assign result.result_kind           = out_q.kind;
	assign result.value                 = out_q.value;
	assign result.too_large             = out_q.too_large;
	assign result.declared_length_bytes = out_q.decl;
	assign result.last_message_byte     = out_q.last;

endmodule : lsb_stego_embed_extract
`default_nettype wire
